### sv/dsp_pkg.sv
// Shared types and character constants of the decimal string parser.
package dsp_pkg;

	// Accumulator holds up to 19 decimal digits before saturation
	localparam int ACC_W     = 64;
	localparam int MANT_W    = 60;
	localparam int CNT_W     = 5;
	localparam int IN_DATA_W = 8;
	localparam int OUT_DATA_W = 72;

	typedef logic [ACC_W-1:0]  acc_t;
	typedef logic [MANT_W-1:0] mant_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [IN_DATA_W-1:0] char_t;

	// Characters the parser recognizes
	localparam char_t CH_NUL   = 8'h00;
	localparam char_t CH_TAB   = 8'h09;
	localparam char_t CH_CR    = 8'h0D;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_PLUS  = 8'h2B;
	localparam char_t CH_COMMA = 8'h2C;
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_DOT   = 8'h2E;
	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_NINE  = 8'h39;

	// Parse phase, one-hot
	typedef enum logic [2:0] {
		PH_WS     = 3'b001,
		PH_BODY   = 3'b010,
		PH_REJECT = 3'b100
	} phase_t;

	// Running parse state
	typedef struct packed {
		phase_t phase;
		logic   negative_sign;
		logic   seen_digit;
		logic   seen_separator;
		acc_t   mantissa_accum;
		cnt_t   digit_count;
		cnt_t   fraction_count;
		logic   overflow_seen;
	} parse_state_t;

	localparam parse_state_t PARSE_RESET = '{
		phase:          PH_WS,
		negative_sign:  1'b0,
		seen_digit:     1'b0,
		seen_separator: 1'b0,
		mantissa_accum: '0,
		digit_count:    '0,
		fraction_count: '0,
		overflow_seen:  1'b0
	};

	// One parse result
	typedef struct packed {
		logic  is_valid;
		logic  is_negative;
		mant_t digit_mantissa;
		cnt_t  fraction_digits;
		logic  digits_overflowed;
	} parse_result_t;

endpackage

### sv/dsp_step.sv
// Next-state and result logic for one character of the decimal string parser.
module dsp_step #(
	parameter int MAX_DIGITS = 18
) (
	input  dsp_pkg::parse_state_t  cur,
	input  dsp_pkg::char_t         text_byte,
	output dsp_pkg::parse_state_t  nxt,
	output dsp_pkg::parse_result_t res
);

	localparam int LIMIT = (MAX_DIGITS > 19) ? 19 : MAX_DIGITS;
	localparam dsp_pkg::cnt_t DIGIT_LIMIT = dsp_pkg::cnt_t'(LIMIT);

	logic is_digit;
	logic is_sep;
	logic is_space;
	logic is_sign;
	logic do_body;
	logic ok;
	logic sat;
	dsp_pkg::acc_t acc_times_ten;

	// Character classes
	assign is_digit = (text_byte >= dsp_pkg::CH_ZERO) && (text_byte <= dsp_pkg::CH_NINE);
	assign is_sep   = (text_byte == dsp_pkg::CH_DOT) || (text_byte == dsp_pkg::CH_COMMA);
	assign is_space = (text_byte == dsp_pkg::CH_SPACE) ||
		((text_byte >= dsp_pkg::CH_TAB) && (text_byte <= dsp_pkg::CH_CR));
	assign is_sign  = (text_byte == dsp_pkg::CH_MINUS) || (text_byte == dsp_pkg::CH_PLUS);

	// Body handling applies in body phase, or for the first non-blank non-sign char
	assign do_body = (cur.phase == dsp_pkg::PH_BODY) ||
		((cur.phase == dsp_pkg::PH_WS) && !is_space && !is_sign);

	// acc*10 + digit as shift-add
	assign acc_times_ten = (cur.mantissa_accum << 3) + (cur.mantissa_accum << 1)
		+ {{(dsp_pkg::ACC_W-4){1'b0}}, text_byte[3:0]};

	// Result fields at the terminator
	assign ok  = (cur.phase != dsp_pkg::PH_REJECT) && cur.seen_digit;
	assign sat = |cur.mantissa_accum[dsp_pkg::ACC_W-1:dsp_pkg::MANT_W];

	always_comb begin
		res.is_valid          = ok;
		res.is_negative       = ok && cur.negative_sign;
		res.digit_mantissa    = '0;
		res.fraction_digits   = '0;
		res.digits_overflowed = ok && (cur.overflow_seen || sat);
		if (ok) begin
			res.digit_mantissa  = sat ? '1 : cur.mantissa_accum[dsp_pkg::MANT_W-1:0];
			res.fraction_digits = cur.fraction_count;
		end
	end

	// State update
	always_comb begin
		nxt = cur;
		if (text_byte == dsp_pkg::CH_NUL) begin
			nxt = dsp_pkg::PARSE_RESET;
		end else if (cur.phase == dsp_pkg::PH_REJECT) begin
			nxt.phase = dsp_pkg::PH_REJECT;
		end else if (do_body) begin
			nxt.phase = dsp_pkg::PH_BODY;
			if (is_digit) begin
				nxt.seen_digit = 1'b1;
				if (cur.digit_count < DIGIT_LIMIT) begin
					nxt.mantissa_accum = acc_times_ten;
					nxt.digit_count    = cur.digit_count + 1'b1;
					if (cur.seen_separator) begin
						nxt.fraction_count = cur.fraction_count + 1'b1;
					end
				end else begin
					nxt.overflow_seen = 1'b1;
				end
			end else if (is_sep && !cur.seen_separator) begin
				nxt.seen_separator = 1'b1;
			end else begin
				nxt.phase = dsp_pkg::PH_REJECT;
			end
		end else if (is_sign) begin
			nxt.phase         = dsp_pkg::PH_BODY;
			nxt.negative_sign = (text_byte == dsp_pkg::CH_MINUS);
		end
	end

endmodule

### sv/decimal_string_parser.sv
// Top level of the decimal string parser: input register, parse state, result register.
// Takes a NUL-terminated text one byte per transfer and, at the NUL, delivers one result
// (valid, sign, decimal mantissa, fraction digit count, overflow); other bytes give no
// result. Leading whitespace and one sign are allowed, then digits and at most one '.'
// or ','. A byte can be accepted every cycle: each byte passes through the input
// register and is folded into the parse state by one multiply-by-ten shift-add. A result
// is loaded into the output register at the same edge its NUL leaves the input register,
// so m_tvalid comes from the output register and the result is held there until the sink
// takes it. Input stalls only while a NUL waits behind a result that the sink has not
// taken.
module decimal_string_parser #(
	parameter int MAX_DIGITS = 18
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // [0] is_valid, [1] is_negative, [61:2] digit_mantissa,
	                               // [66:62] fraction_digits, [67] digits_overflowed
);

	localparam int LIMIT = (MAX_DIGITS > 19) ? 19 : MAX_DIGITS;
	localparam dsp_pkg::cnt_t DIGIT_LIMIT = dsp_pkg::cnt_t'(LIMIT);

	logic                   valid_s1;
	dsp_pkg::char_t         byte_s1;
	logic                   advance_s1;
	logic                   is_nul_s1;
	dsp_pkg::parse_state_t  state_q;
	dsp_pkg::parse_state_t  state_nxt;
	dsp_pkg::parse_result_t res_nxt;
	dsp_pkg::parse_result_t res_q;
	logic                   out_valid_q;

	// A NUL moves on only if the result register is free or being drained
	assign is_nul_s1  = (byte_s1 == dsp_pkg::CH_NUL);
	assign advance_s1 = !is_nul_s1 || !out_valid_q || m_tready;
	assign s_tready   = !valid_s1 || advance_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	dsp_step #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_step (
		.cur      (state_q),
		.text_byte(byte_s1),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsp_pkg::PARSE_RESET;
		end else if (valid_s1 && advance_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && is_nul_s1 && advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && is_nul_s1 && advance_s1) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, res_q.digits_overflowed, res_q.fraction_digits,
		res_q.digit_mantissa, res_q.is_negative, res_q.is_valid};

`ifndef SYNTHESIS
	// A NUL leaving the input register always loads a result
	a_nul_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && is_nul_s1 && advance_s1) |=> out_valid_q)
		else $error("NUL transfer did not produce a result");

	// Invalid results carry all-zero fields
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.is_valid) |-> (res_q.digit_mantissa == '0 &&
		res_q.fraction_digits == '0 && !res_q.is_negative && !res_q.digits_overflowed))
		else $error("invalid result with nonzero fields");

	// Held digit count never passes the limit
	a_digit_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.digit_count <= DIGIT_LIMIT)
		else $error("digit count beyond limit");

	// Fraction digits are a subset of held digits
	a_frac_le_digits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.fraction_count <= state_q.digit_count)
		else $error("fraction count exceeds digit count");
`endif

endmodule
